[sv/apwc_pkg.sv]
// Package for the anti-pinch window controller.
// Holds the transaction payload types, configuration struct, codes and reset values.
// No dependencies.
package apwc_pkg;

  // Input transaction kinds
  localparam logic KIND_MOTOR = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Commands carried by a motor transaction
  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_OPEN_FULL   = 3'd1;
  localparam logic [2:0] CMD_CLOSE_FULL  = 3'd2;
  localparam logic [2:0] CMD_OPEN_NUDGE  = 3'd3;
  localparam logic [2:0] CMD_CLOSE_NUDGE = 3'd4;
  localparam logic [2:0] CMD_STOP        = 3'd5;

  // Window modes
  localparam logic [2:0] MODE_STOPPED    = 3'd0;
  localparam logic [2:0] MODE_OPENING    = 3'd1;
  localparam logic [2:0] MODE_CLOSING    = 3'd2;
  localparam logic [2:0] MODE_OPEN_DONE  = 3'd3;
  localparam logic [2:0] MODE_CLOSE_DONE = 3'd4;
  localparam logic [2:0] MODE_REVERSING  = 3'd5;

  // Step directions
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_OPEN  = 2'd1;
  localparam logic [1:0] DIR_CLOSE = 2'd2;

  // Voice cues
  localparam logic [1:0] CUE_NONE       = 2'd0;
  localparam logic [1:0] CUE_OPEN_DONE  = 2'd1;
  localparam logic [1:0] CUE_CLOSE_DONE = 2'd2;
  localparam logic [1:0] CUE_PINCH      = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FULL_TRAVEL = 3'd0;
  localparam logic [2:0] REG_NUDGE       = 3'd1;
  localparam logic [2:0] REG_REVERSE     = 3'd2;
  localparam logic [2:0] REG_STEP        = 3'd3;
  localparam logic [2:0] REG_ALARM_HOLD  = 3'd4;
  localparam logic [2:0] REG_ALARM_BLINK = 3'd5;

  localparam int unsigned ADDR_W = 5;

  // Register reset values
  localparam logic [15:0] RST_FULL_TRAVEL = 16'd3600;
  localparam logic [15:0] RST_NUDGE       = 16'd90;
  localparam logic [15:0] RST_REVERSE     = 16'd360;
  localparam logic [15:0] RST_STEP        = 16'd9;
  localparam logic [15:0] RST_ALARM_HOLD  = 16'd1200;
  localparam logic [15:0] RST_ALARM_BLINK = 16'd200;

  typedef struct packed {
    logic       kind;
    logic [2:0] command;
    logic       pinch;
  } in_item_t;

  typedef struct packed {
    logic [2:0] window_state;
    logic [1:0] step_request;
    logic       motor_stop;
    logic       alarm_running;
    logic       alarm_output;
    logic [1:0] voice_cue;
    logic       state_changed;
  } out_item_t;

  typedef struct packed {
    logic [15:0] full_travel_deg;
    logic [15:0] nudge_deg;
    logic [15:0] reverse_deg;
    logic [15:0] step_deg;
    logic [15:0] alarm_hold_ms;
    logic [15:0] alarm_blink_ms;
  } cfg_t;

endpackage

[sv/anti_pinch_window_controller_unit.sv]
// Top level of the anti-pinch window controller: input register, result register, handshakes.
// Depends on apwc_pkg, apwc_regs and apwc_ctrl.
//
// One result transaction per input transaction (motor step or millisecond tick). The block
// takes a new transaction every clock unless the input register holds one that cannot move on
// because the result register is stalled; an accepted transaction sits in the input register
// and passes the window/alarm next-state logic into the result register. The result register
// lets a new input be accepted while a finished result waits. The user must write configuration
// through the APB-style port only while no transaction is in flight; the block itself does not
// enforce this. Reads return the 16-bit register values zero-extended.
module anti_pinch_window_controller_unit import apwc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_ready,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      stage_valid;
  out_item_t ctrl_res;
  logic      fire;
  logic      item_accept;

  assign fire        = stage_valid & (~result_valid | result_ready);
  assign item_ready  = ~stage_valid | fire;
  assign item_accept = item_valid & item_ready;

  apwc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  apwc_ctrl u_ctrl (
    .clk, .rst, .cfg, .fire, .item(stage_item), .res(ctrl_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= item_accept | (stage_valid & ~fire);
    end
    if (item_accept) stage_item <= item;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= fire | (result_valid & ~result_ready);
    end
    if (fire) result <= ctrl_res;
  end

endmodule

[sv/apwc_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on apwc_pkg for the register indexes, reset values and cfg_t.
module apwc_regs import apwc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_travel_deg <= RST_FULL_TRAVEL;
      cfg.nudge_deg       <= RST_NUDGE;
      cfg.reverse_deg     <= RST_REVERSE;
      cfg.step_deg        <= RST_STEP;
      cfg.alarm_hold_ms   <= RST_ALARM_HOLD;
      cfg.alarm_blink_ms  <= RST_ALARM_BLINK;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FULL_TRAVEL: cfg.full_travel_deg <= pwdata[15:0];
        REG_NUDGE:       cfg.nudge_deg       <= pwdata[15:0];
        REG_REVERSE:     cfg.reverse_deg     <= pwdata[15:0];
        REG_STEP:        cfg.step_deg        <= pwdata[15:0];
        REG_ALARM_HOLD:  cfg.alarm_hold_ms   <= pwdata[15:0];
        REG_ALARM_BLINK: cfg.alarm_blink_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_FULL_TRAVEL: prdata = {16'd0, cfg.full_travel_deg};
      REG_NUDGE:       prdata = {16'd0, cfg.nudge_deg};
      REG_REVERSE:     prdata = {16'd0, cfg.reverse_deg};
      REG_STEP:        prdata = {16'd0, cfg.step_deg};
      REG_ALARM_HOLD:  prdata = {16'd0, cfg.alarm_hold_ms};
      REG_ALARM_BLINK: prdata = {16'd0, cfg.alarm_blink_ms};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[sv/apwc_ctrl.sv]
// Window and alarm state with the single-pass next-state logic for one transaction.
// Depends on apwc_pkg for codes, in_item_t, out_item_t and cfg_t.
module apwc_ctrl import apwc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  logic [2:0]  window_mode, window_mode_next;
  logic [15:0] travel_left, travel_left_next;
  logic        nudge_mode, nudge_mode_next;
  logic [15:0] reverse_left, reverse_left_next;
  logic        alarm_on, alarm_on_next;
  logic        alarm_level, alarm_level_next;
  logic [15:0] hold_count, hold_count_next;
  logic [15:0] blink_count, blink_count_next;

  logic [1:0]  step_q;
  logic        stop_q;
  logic [1:0]  cue_q;
  logic        chg_q;
  logic [2:0]  cmd_mode;
  logic        cmd_nudge;
  logic [1:0]  mv_dir;
  logic [2:0]  mv_done;
  logic [1:0]  mv_cue;
  logic [15:0] blink_inc;

  always_comb begin
    window_mode_next  = window_mode;
    travel_left_next  = travel_left;
    nudge_mode_next   = nudge_mode;
    reverse_left_next = reverse_left;
    alarm_on_next     = alarm_on;
    alarm_level_next  = alarm_level;
    hold_count_next   = hold_count;
    blink_count_next  = blink_count;
    step_q            = DIR_NONE;
    stop_q            = 1'b0;
    cue_q             = CUE_NONE;
    chg_q             = 1'b0;
    cmd_mode          = MODE_OPENING;
    cmd_nudge         = 1'b0;
    mv_dir            = DIR_OPEN;
    mv_done           = MODE_OPEN_DONE;
    mv_cue            = CUE_OPEN_DONE;
    blink_inc         = (blink_count == 16'hFFFF) ? blink_count : blink_count + 16'd1;

    if (item.kind == KIND_MOTOR) begin
      // Command first
      case (item.command)
        CMD_OPEN_FULL, CMD_CLOSE_FULL, CMD_OPEN_NUDGE, CMD_CLOSE_NUDGE: begin
          cmd_mode  = (item.command == CMD_CLOSE_FULL || item.command == CMD_CLOSE_NUDGE)
                      ? MODE_CLOSING : MODE_OPENING;
          cmd_nudge = (item.command == CMD_OPEN_NUDGE || item.command == CMD_CLOSE_NUDGE);
          travel_left_next  = cmd_nudge ? cfg.nudge_deg : cfg.full_travel_deg;
          nudge_mode_next   = cmd_nudge;
          reverse_left_next = 16'd0;
          if (window_mode_next != cmd_mode) chg_q = 1'b1;
          window_mode_next  = cmd_mode;
        end
        CMD_STOP: begin
          stop_q            = 1'b1;
          nudge_mode_next   = 1'b0;
          travel_left_next  = 16'd0;
          reverse_left_next = 16'd0;
          if (window_mode_next != MODE_STOPPED) chg_q = 1'b1;
          window_mode_next  = MODE_STOPPED;
        end
        default: ;
      endcase

      // Pinch check, then stepping for the current mode
      if (window_mode_next == MODE_CLOSING && item.pinch) begin
        travel_left_next  = 16'd0;
        nudge_mode_next   = 1'b0;
        reverse_left_next = cfg.reverse_deg;
        chg_q             = 1'b1;
        window_mode_next  = MODE_REVERSING;
        alarm_on_next     = 1'b1;
        hold_count_next   = cfg.alarm_hold_ms;
        blink_count_next  = 16'd0;
        alarm_level_next  = 1'b1;
        cue_q             = CUE_PINCH;
      end else if (window_mode_next == MODE_OPENING || window_mode_next == MODE_CLOSING) begin
        if (window_mode_next == MODE_CLOSING) begin
          mv_dir  = DIR_CLOSE;
          mv_done = MODE_CLOSE_DONE;
          mv_cue  = CUE_CLOSE_DONE;
        end
        step_q = mv_dir;
        if (travel_left_next <= cfg.step_deg) begin
          stop_q           = 1'b1;
          travel_left_next = 16'd0;
          chg_q            = 1'b1;
          if (nudge_mode_next) begin
            nudge_mode_next  = 1'b0;
            window_mode_next = MODE_STOPPED;
          end else begin
            reverse_left_next = 16'd0;
            window_mode_next  = mv_done;
            alarm_on_next     = 1'b1;
            hold_count_next   = cfg.alarm_hold_ms;
            blink_count_next  = 16'd0;
            alarm_level_next  = 1'b1;
            cue_q             = mv_cue;
          end
        end else begin
          travel_left_next = travel_left_next - cfg.step_deg;
        end
      end else if (window_mode_next == MODE_REVERSING) begin
        if (reverse_left_next == 16'd0) begin
          // Reverse used up: window counts as fully open
          stop_q           = 1'b1;
          nudge_mode_next  = 1'b0;
          travel_left_next = 16'd0;
          chg_q            = 1'b1;
          window_mode_next = MODE_OPEN_DONE;
          alarm_on_next    = 1'b1;
          hold_count_next  = cfg.alarm_hold_ms;
          blink_count_next = 16'd0;
          alarm_level_next = 1'b1;
          cue_q            = CUE_OPEN_DONE;
        end else begin
          step_q = DIR_OPEN;
          reverse_left_next = (reverse_left_next <= cfg.step_deg) ? 16'd0
                              : reverse_left_next - cfg.step_deg;
        end
      end
    end else if (alarm_on) begin
      // Millisecond tick: hold and blink timers
      if (hold_count <= 16'd1) begin
        hold_count_next  = 16'd0;
        alarm_on_next    = 1'b0;
        alarm_level_next = 1'b0;
        blink_count_next = 16'd0;
        chg_q            = 1'b1;
      end else begin
        hold_count_next = hold_count - 16'd1;
        if (blink_inc >= cfg.alarm_blink_ms) begin
          alarm_level_next = ~alarm_level;
          blink_count_next = 16'd0;
        end else begin
          blink_count_next = blink_inc;
        end
      end
    end
  end

  assign res.window_state  = window_mode_next;
  assign res.step_request  = step_q;
  assign res.motor_stop    = stop_q;
  assign res.alarm_running = alarm_on_next;
  assign res.alarm_output  = alarm_level_next;
  assign res.voice_cue     = cue_q;
  assign res.state_changed = chg_q;

  // State update on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode  <= MODE_STOPPED;
      travel_left  <= 16'd0;
      nudge_mode   <= 1'b0;
      reverse_left <= 16'd0;
      alarm_on     <= 1'b0;
      alarm_level  <= 1'b0;
      hold_count   <= 16'd0;
      blink_count  <= 16'd0;
    end else if (fire) begin
      window_mode  <= window_mode_next;
      travel_left  <= travel_left_next;
      nudge_mode   <= nudge_mode_next;
      reverse_left <= reverse_left_next;
      alarm_on     <= alarm_on_next;
      alarm_level  <= alarm_level_next;
      hold_count   <= hold_count_next;
      blink_count  <= blink_count_next;
    end
  end

endmodule

[sv/apwc_checker.sv]
// Port-level checks for the anti-pinch window controller, bound to the top level.
// Depends on apwc_pkg and anti_pinch_window_controller_unit.
module apwc_checker import apwc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Only none, open or close step codes
  a_step_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.step_request != 2'd3)
    else $error("illegal step request code");

  // Buzzer only drives during the hold period
  a_alarm_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.alarm_output |-> result.alarm_running)
    else $error("alarm output without active alarm");

  // A pinch cue starts the reverse with the alarm on and no step yet
  a_pinch_cue: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.voice_cue == CUE_PINCH |->
      result.window_state == MODE_REVERSING && result.alarm_running &&
      result.alarm_output && result.step_request == DIR_NONE)
    else $error("pinch cue inconsistent with result");

endmodule

bind anti_pinch_window_controller_unit apwc_checker u_apwc_checker (
  .clk, .rst, .result_valid, .result_ready, .result
);

[tb/anti_pinch_window_controller_unit_tb.sv]
// Self-checking testbench for anti_pinch_window_controller_unit.
// Depends on apwc_pkg and the RTL. A transaction-level status predictor runs in the monitor, and
// results are checked in order under random valid/ready idling and APB register changes.
module anti_pinch_window_controller_unit_tb import apwc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // Pending input entry: hold marks a pause until every status has come back
  typedef struct packed {
    logic       hold;
    logic [3:0] gap;
    in_item_t   it;
  } pend_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  in_item_t          item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  out_item_t         result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  anti_pinch_window_controller_unit dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  // Predictor state: register shadow and window/alarm state
  cfg_t        cfg = {RST_FULL_TRAVEL, RST_NUDGE, RST_REVERSE, RST_STEP,
                      RST_ALARM_HOLD, RST_ALARM_BLINK};
  logic [2:0]  win_mode = MODE_STOPPED;
  logic [15:0] travel_left = '0;
  logic        nudge_on = 1'b0;
  logic [15:0] reverse_left = '0;
  logic        alarm_on = 1'b0;
  logic        alarm_lvl = 1'b0;
  logic [15:0] hold_cnt = '0;
  logic [15:0] blink_cnt = '0;
  out_item_t   pred;

  pend_t       window_events_q[$];
  out_item_t   status_q[$];
  out_item_t   want;
  int          fault_cnt = 0;
  bit          item_fire = 1'b0;
  bit          result_fire = 1'b0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int          gap_left = 0;
  bit          gap_done = 1'b0;
  int          stall_left = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void set_mode(logic [2:0] m);
    if (win_mode != m) begin
      win_mode = m;
      pred.state_changed = 1'b1;
    end
  endfunction

  function automatic void start_alarm(logic [1:0] cue);
    alarm_on = 1'b1;
    hold_cnt = cfg.alarm_hold_ms;
    blink_cnt = '0;
    alarm_lvl = 1'b1;
    pred.voice_cue = cue;
  endfunction

  function automatic void end_move(logic [2:0] done_mode, logic [1:0] cue);
    pred.motor_stop = 1'b1;
    nudge_on = 1'b0;
    travel_left = '0;
    reverse_left = '0;
    set_mode(done_mode);
    start_alarm(cue);
  endfunction

  function automatic void start_travel(logic [2:0] m, logic nudge);
    travel_left = nudge ? cfg.nudge_deg : cfg.full_travel_deg;
    nudge_on = nudge;
    reverse_left = '0;
    set_mode(m);
  endfunction

  // One step toward the target; nudges end stopped, full moves end done with alarm
  function automatic void advance(logic [1:0] dir, logic [2:0] done_mode, logic [1:0] cue);
    pred.step_request = dir;
    if (travel_left <= cfg.step_deg) begin
      if (nudge_on) begin
        nudge_on = 1'b0;
        travel_left = '0;
        pred.motor_stop = 1'b1;
        set_mode(MODE_STOPPED);
      end else begin
        end_move(done_mode, cue);
      end
    end else begin
      travel_left = travel_left - cfg.step_deg;
    end
  endfunction

  function automatic out_item_t predict_window_status(in_item_t it);
    pred = '0;
    if (it.kind == KIND_MOTOR) begin
      // command first, then pinch check, then stepping
      case (it.command)
        CMD_OPEN_FULL:   start_travel(MODE_OPENING, 1'b0);
        CMD_CLOSE_FULL:  start_travel(MODE_CLOSING, 1'b0);
        CMD_OPEN_NUDGE:  start_travel(MODE_OPENING, 1'b1);
        CMD_CLOSE_NUDGE: start_travel(MODE_CLOSING, 1'b1);
        CMD_STOP: begin
          pred.motor_stop = 1'b1;
          nudge_on = 1'b0;
          travel_left = '0;
          reverse_left = '0;
          set_mode(MODE_STOPPED);
        end
        default: ;
      endcase
      if (win_mode == MODE_CLOSING && it.pinch) begin
        travel_left = '0;
        nudge_on = 1'b0;
        reverse_left = cfg.reverse_deg;
        set_mode(MODE_REVERSING);
        start_alarm(CUE_PINCH);
      end else if (win_mode == MODE_OPENING) begin
        advance(DIR_OPEN, MODE_OPEN_DONE, CUE_OPEN_DONE);
      end else if (win_mode == MODE_CLOSING) begin
        advance(DIR_CLOSE, MODE_CLOSE_DONE, CUE_CLOSE_DONE);
      end else if (win_mode == MODE_REVERSING) begin
        if (reverse_left == '0) begin
          end_move(MODE_OPEN_DONE, CUE_OPEN_DONE);
        end else begin
          pred.step_request = DIR_OPEN;
          if (reverse_left <= cfg.step_deg) reverse_left = '0;
          else reverse_left = reverse_left - cfg.step_deg;
        end
      end
    end else if (alarm_on) begin
      // millisecond tick: hold countdown and blink toggling
      if (hold_cnt <= 16'd1) begin
        hold_cnt = '0;
        alarm_on = 1'b0;
        alarm_lvl = 1'b0;
        blink_cnt = '0;
        pred.state_changed = 1'b1;
      end else begin
        hold_cnt = hold_cnt - 16'd1;
        if (blink_cnt != 16'hFFFF) blink_cnt = blink_cnt + 16'd1;
        if (blink_cnt >= cfg.alarm_blink_ms) begin
          alarm_lvl = ~alarm_lvl;
          blink_cnt = '0;
        end
      end
    end
    pred.window_state = win_mode;
    pred.alarm_running = alarm_on;
    pred.alarm_output = alarm_lvl;
    return pred;
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    item_fire <= !rst && item_valid && item_ready;
    result_fire <= !rst && result_valid && result_ready;
    if (!rst && item_valid && item_ready) status_q.push_back(predict_window_status(item));
    if (!rst && result_valid && result_ready) begin
      if (status_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("%0t: unexpected result transaction %h", $realtime, result);
      end else begin
        want = status_q.pop_front();
        if (result !== want) begin
          fault_cnt++;
          if (fault_cnt <= 10) begin
            $display("%0t: exp state=%0d step=%0d stop=%0d act=%0d out=%0d cue=%0d chg=%0d",
                     $realtime, want.window_state, want.step_request, want.motor_stop,
                     want.alarm_running, want.alarm_output, want.voice_cue,
                     want.state_changed);
            $display("%0t: got state=%0d step=%0d stop=%0d act=%0d out=%0d cue=%0d chg=%0d",
                     $realtime, result.window_state, result.step_request, result.motor_stop,
                     result.alarm_running, result.alarm_output, result.voice_cue,
                     result.state_changed);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (window_events_q.size() != 0 && window_events_q[0].hold) begin
        // pause until all outstanding statuses are back
        item_valid <= 1'b0;
        if (status_q.size() == 0) void'(window_events_q.pop_front());
      end else if (window_events_q.size() != 0) begin
        if (!gap_done && window_events_q[0].gap != 0) begin
          gap_left = window_events_q[0].gap - 1;
          gap_done = 1'b1;
          item_valid <= 1'b0;
        end else begin
          item <= window_events_q[0].it;
          item_valid <= 1'b1;
          void'(window_events_q.pop_front());
          gap_done = 1'b0;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: random stall after each accepted result, with calm stretches
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_fire) begin
        if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic add_event(in_item_t it);
    pend_t e;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    e.hold = 1'b0;
    e.gap = send_calm ? 4'd0 : 4'($urandom_range(0, 11));
    e.it = it;
    window_events_q.push_back(e);
  endtask

  task automatic add_hold();
    pend_t e;
    e = '0;
    e.hold = 1'b1;
    window_events_q.push_back(e);
  endtask

  task automatic motor(logic [2:0] cmd, logic pinch);
    add_event({KIND_MOTOR, cmd, pinch});
  endtask

  task automatic tick();
    add_event({KIND_TICK, 3'($urandom), 1'($urandom)});
  endtask

  // Wait until nothing is pending or in flight
  task automatic settle();
    while (window_events_q.size() != 0 || item_valid || status_q.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FULL_TRAVEL: cfg.full_travel_deg = val;
      REG_NUDGE:       cfg.nudge_deg = val;
      REG_REVERSE:     cfg.reverse_deg = val;
      REG_STEP:        cfg.step_deg = val;
      REG_ALARM_HOLD:  cfg.alarm_hold_ms = val;
      REG_ALARM_BLINK: cfg.alarm_blink_ms = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] full, logic [15:0] nudge, logic [15:0] rev,
                            logic [15:0] step, logic [15:0] hold, logic [15:0] blink);
    reg_write(REG_FULL_TRAVEL, full);
    reg_write(REG_NUDGE, nudge);
    reg_write(REG_REVERSE, rev);
    reg_write(REG_STEP, step);
    reg_write(REG_ALARM_HOLD, hold);
    reg_write(REG_ALARM_BLINK, blink);
  endtask

  // Mostly plain motor steps so moves run to completion; some commands, pinches, ticks
  task automatic queue_random(int n);
    int unsigned roll;
    logic [2:0]  cmd;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        tick();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) cmd = 3'($urandom_range(1, 5));
        else if (roll < 10) cmd = 3'($urandom_range(6, 7));
        else cmd = CMD_NONE;
        motor(cmd, $urandom_range(0, 24) == 0);
      end
      if ($urandom_range(0, 149) == 0) add_hold();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: short travel so every path finishes quickly
    set_config(16'd36, 16'd18, 16'd27, 16'd9, 16'd5, 16'd2);
    @(posedge clk);
    tick();                               // tick with alarm idle, noisy fields
    motor(CMD_NONE, 1'b0);
    motor(CMD_OPEN_FULL, 1'b1);           // pinch ignored while opening
    repeat (3) motor(CMD_NONE, 1'b0);     // reaches open done
    tick();
    tick();                               // blink toggle
    motor(CMD_CLOSE_NUDGE, 1'b0);
    motor(CMD_NONE, 1'b0);                // nudge ends stopped
    add_hold();
    motor(CMD_CLOSE_FULL, 1'b0);
    motor(CMD_NONE, 1'b1);                // pinch while closing
    repeat (4) motor(CMD_NONE, 1'b0);     // reverse then open done
    motor(CMD_SPARE6, 1'b1);
    motor(CMD_SPARE7, 1'b0);
    motor(CMD_CLOSE_FULL, 1'b1);          // command and pinch in one transaction
    motor(CMD_STOP, 1'b0);
    motor(CMD_OPEN_NUDGE, 1'b0);
    repeat (4) tick();                    // alarm hold counts down
    settle();

    set_config(16'd40, 16'd20, 16'd30, 16'd7, 16'd15, 16'd3);
    @(posedge clk);
    queue_random(120);
    add_hold();
    queue_random(130);
    settle();

    // low extremes: zero travel, single-degree steps, shortest alarm
    set_config(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
    @(posedge clk);
    queue_random(150);
    settle();

    // high extremes
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    queue_random(150);
    settle();

    // zero step size, zero hold and zero blink
    set_config(16'd50, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    @(posedge clk);
    queue_random(150);
    settle();

    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom_range(0, 100)), 16'($urandom_range(0, 40)),
                 16'($urandom_range(0, 60)), 16'($urandom_range(1, 20)),
                 16'($urandom_range(1, 30)), 16'($urandom_range(0, 8)));
      @(posedge clk);
      queue_random(100);
      settle();
    end

    // catch any stray result after the last one
    repeat (10) @(posedge clk);
    if (fault_cnt == 0 && status_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
